### rtl/pcsd_pkg.sv
package pcsd_pkg;

	typedef logic signed [31:0] coord_t;
	typedef logic [2:0] cfg_idx_t;

	localparam cfg_idx_t CFG_START_X = 3'd0;
	localparam cfg_idx_t CFG_START_Y = 3'd1;
	localparam cfg_idx_t CFG_START_Z = 3'd2;
	localparam cfg_idx_t CFG_AXIS_X  = 3'd3;
	localparam cfg_idx_t CFG_AXIS_Y  = 3'd4;
	localparam cfg_idx_t CFG_AXIS_Z  = 3'd5;
	localparam cfg_idx_t CFG_RADIUS  = 3'd6;

	localparam int GUARD_BITS = 16;
	localparam int ROOT_W     = 50;
	localparam int REM_W      = 168;
	localparam int TRK_W      = 116;
	localparam int SQ_W       = 132;
	localparam int MAG_ROOT_W = 51;
	localparam int MAG_REM_W  = 104;
	localparam int N_STAGES   = 9 + ROOT_W + 3 + MAG_ROOT_W + 1;

	typedef struct packed {
		logic in_rad;
		logic degen;
	} flags_t;

endpackage

### rtl/pcsd_stream_if.sv
interface pcsd_in_if;
	logic valid;
	logic ready;
	pcsd_pkg::coord_t point_x;
	pcsd_pkg::coord_t point_y;
	pcsd_pkg::coord_t point_z;
	modport source(output valid, output point_x, output point_y, output point_z, input ready);
	modport sink(input valid, input point_x, input point_y, input point_z, output ready);
endinterface

interface pcsd_out_if;
	logic valid;
	logic ready;
	pcsd_pkg::coord_t signed_distance;
	logic degenerate_axis;
	logic saturated;
	modport source(output valid, output signed_distance, output degenerate_axis,
		output saturated, input ready);
	modport sink(input valid, input signed_distance, input degenerate_axis,
		input saturated, output ready);
endinterface

### rtl/point_to_cylinder_signed_distance_top.sv
// Signed distance from a point to a finite cylinder, one point per beat.
// Write the cylinder (start x/y/z, axis x/y/z, radius) on wr_en/wr_index/
// wr_data while no beat is in flight; indexes past the radius are dropped.
// Input beats arrive on the point channel, results leave on the result
// channel, one result beat per input beat, in order.
// Pipeline from an accepted input beat to its result beat: 9 stages of
// products and sums, 50 stages of bit-serial root search for the radial and
// axial terms (each with its own shift-add tracking of root*axis^2), 3 stages
// of hull, squares and sum, 51 stages of square root, 1 output.
// Throughput: one beat per cycle while the receiver takes results.
// Reset clears the configuration to zero and empties the pipeline.
// When the receiver stalls the whole pipeline holds, point.ready drops and
// nothing is lost or repeated; ready returns the cycle the result is taken.
// A zero axis gives distance 0 with degenerate_axis set.
module point_to_cylinder_signed_distance_top (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                wr_en,
	input  pcsd_pkg::cfg_idx_t  wr_index,
	input  logic [31:0]         wr_data,
	pcsd_in_if.sink             point,
	pcsd_out_if.source          result
);

	localparam int RW  = pcsd_pkg::ROOT_W;
	localparam int W   = pcsd_pkg::REM_W;
	localparam int W1  = pcsd_pkg::REM_W + 1;
	localparam int TW  = pcsd_pkg::TRK_W;
	localparam int NW  = pcsd_pkg::SQ_W;
	localparam int MW  = pcsd_pkg::MAG_ROOT_W;
	localparam int SW  = pcsd_pkg::MAG_REM_W;
	localparam int SW1 = pcsd_pkg::MAG_REM_W + 1;
	localparam int NST = pcsd_pkg::N_STAGES;
	localparam int GB  = pcsd_pkg::GUARD_BITS;

	pcsd_pkg::coord_t start_q [3];
	pcsd_pkg::coord_t axis_q [3];
	logic [30:0]      radius_q;

	logic             en;
	logic [NST:1]     vld_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 3; i++) begin
				start_q[i] <= '0;
				axis_q[i]  <= '0;
			end
			radius_q <= '0;
		end else if (wr_en) begin
			case (wr_index)
				pcsd_pkg::CFG_START_X: start_q[0] <= wr_data;
				pcsd_pkg::CFG_START_Y: start_q[1] <= wr_data;
				pcsd_pkg::CFG_START_Z: start_q[2] <= wr_data;
				pcsd_pkg::CFG_AXIS_X:  axis_q[0]  <= wr_data;
				pcsd_pkg::CFG_AXIS_Y:  axis_q[1]  <= wr_data;
				pcsd_pkg::CFG_AXIS_Z:  axis_q[2]  <= wr_data;
				pcsd_pkg::CFG_RADIUS:  radius_q   <= wr_data[30:0];
				default: ;
			endcase
		end
	end

	assign en          = !vld_q[NST] || result.ready;
	assign point.ready = en;
	assign result.valid = vld_q[NST];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (en) begin
			vld_q <= {vld_q[NST-1:1], point.valid};
		end
	end

	// s1: differences and magnitudes
	pcsd_pkg::coord_t pt [3];
	logic [32:0] dif [3];
	logic [31:0] ud_c [3];
	logic [31:0] ua_c [3];

	assign pt[0] = point.point_x;
	assign pt[1] = point.point_y;
	assign pt[2] = point.point_z;

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			dif[i]  = {pt[i][31], pt[i]} - {start_q[i][31], start_q[i]};
			ud_c[i] = dif[i][32] ? 32'(-dif[i]) : dif[i][31:0];
			ua_c[i] = axis_q[i][31] ? 32'(-axis_q[i]) : axis_q[i];
		end
	end

	logic [31:0] ud_s1 [3];
	logic [31:0] ua_s1 [3];
	logic [2:0]  neg_s1;
	logic [63:0] p_s2 [3];
	logic [63:0] q_s2 [3];
	logic [63:0] u_s2 [3];
	logic [2:0]  neg_s2;
	logic [65:0] dpos_s3, dneg_s3, dd_s3;
	logic [63:0] aa_s3;
	logic signed [66:0] diff_s4;
	logic [65:0] dd_s4;
	logic [63:0] aa_s4;
	logic        degen_s4;
	logic        dotneg_s5;
	logic [65:0] dotm_s5, dd_s5;
	logic [63:0] aa_s5;
	logic        degen_s5;
	logic [65:0] e_s6, dotm_s6, dd_s6;
	logic [63:0] aa_s6;
	logic        degen_s6;
	logic [64:0] ddhh_s7, ddhl_s7, ddlh_s7, ddll_s7;
	logic [65:0] mhh_s7, mhl_s7, mll_s7, ehh_s7, ehl_s7, ell_s7;
	logic [63:0] aa_s7;
	logic        degen_s7;
	logic [NW-1:0] ddaa_s8, dotsq_s8, esq_s8;
	logic [63:0] aa_s8;
	logic        degen_s8;

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				ud_s1[i]  <= ud_c[i];
				ua_s1[i]  <= ua_c[i];
				neg_s1[i] <= dif[i][32] ^ axis_q[i][31];
				p_s2[i]   <= ud_s1[i] * ua_s1[i];
				q_s2[i]   <= ud_s1[i] * ud_s1[i];
				u_s2[i]   <= ua_s1[i] * ua_s1[i];
			end
			neg_s2 <= neg_s1;

			dpos_s3 <= (neg_s2[0] ? 66'd0 : 66'(p_s2[0])) + (neg_s2[1] ? 66'd0 : 66'(p_s2[1]))
				+ (neg_s2[2] ? 66'd0 : 66'(p_s2[2]));
			dneg_s3 <= (neg_s2[0] ? 66'(p_s2[0]) : 66'd0) + (neg_s2[1] ? 66'(p_s2[1]) : 66'd0)
				+ (neg_s2[2] ? 66'(p_s2[2]) : 66'd0);
			dd_s3 <= 66'(q_s2[0]) + 66'(q_s2[1]) + 66'(q_s2[2]);
			aa_s3 <= u_s2[0] + u_s2[1] + u_s2[2];

			diff_s4  <= signed'({1'b0, dpos_s3}) - signed'({1'b0, dneg_s3});
			dd_s4    <= dd_s3;
			aa_s4    <= aa_s3;
			degen_s4 <= (aa_s3 == '0);

			dotneg_s5 <= diff_s4[66];
			dotm_s5   <= diff_s4[66] ? 66'(-diff_s4) : diff_s4[65:0];
			dd_s5     <= dd_s4;
			aa_s5     <= aa_s4;
			degen_s5  <= degen_s4;

			if (dotneg_s5)
				e_s6 <= dotm_s5;
			else if (dotm_s5 >= 66'(aa_s5))
				e_s6 <= dotm_s5 - 66'(aa_s5);
			else
				e_s6 <= '0;
			dotm_s6  <= dotm_s5;
			dd_s6    <= dd_s5;
			aa_s6    <= aa_s5;
			degen_s6 <= degen_s5;

			ddhh_s7 <= dd_s6[65:33] * aa_s6[63:32];
			ddhl_s7 <= dd_s6[65:33] * aa_s6[31:0];
			ddlh_s7 <= dd_s6[32:0] * aa_s6[63:32];
			ddll_s7 <= dd_s6[32:0] * aa_s6[31:0];
			mhh_s7  <= dotm_s6[65:33] * dotm_s6[65:33];
			mhl_s7  <= dotm_s6[65:33] * dotm_s6[32:0];
			mll_s7  <= dotm_s6[32:0] * dotm_s6[32:0];
			ehh_s7  <= e_s6[65:33] * e_s6[65:33];
			ehl_s7  <= e_s6[65:33] * e_s6[32:0];
			ell_s7  <= e_s6[32:0] * e_s6[32:0];
			aa_s7    <= aa_s6;
			degen_s7 <= degen_s6;

			ddaa_s8  <= (NW'(ddhh_s7) << 65) + (NW'(ddhl_s7) << 33) + (NW'(ddlh_s7) << 32)
				+ NW'(ddll_s7);
			dotsq_s8 <= (NW'(mhh_s7) << 66) + (NW'(mhl_s7) << 34) + NW'(mll_s7);
			esq_s8   <= (NW'(ehh_s7) << 66) + (NW'(ehl_s7) << 34) + NW'(ell_s7);
			aa_s8    <= aa_s7;
			degen_s8 <= degen_s7;
		end
	end

	// root search: largest r with r*r*aa <= rem, tracking r*aa
	logic [W-1:0]  rr_s [RW+1];
	logic [TW-1:0] rt_s [RW+1];
	logic [RW-1:0] rroot_s [RW+1];
	logic [W-1:0]  gr_s [RW+1];
	logic [TW-1:0] gt_s [RW+1];
	logic [RW-1:0] groot_s [RW+1];
	logic [63:0]   aa_k_s [RW+1];
	logic          dg_s [RW+1];

	always_ff @(posedge clk) begin
		if (en) begin
			rr_s[0]    <= W'({ddaa_s8 - dotsq_s8, 32'd0});
			gr_s[0]    <= W'({esq_s8, 32'd0});
			rt_s[0]    <= '0;
			gt_s[0]    <= '0;
			rroot_s[0] <= '0;
			groot_s[0] <= '0;
			aa_k_s[0]  <= aa_s8;
			dg_s[0]    <= degen_s8;
		end
	end

	for (genvar j = 0; j < RW; j++) begin : g_srch
		localparam int K = RW - 1 - j;
		logic [W:0] dr, dgv;
		assign dr  = {1'b0, rr_s[j]} - (W1'(rt_s[j]) << (K + 1)) - (W1'(aa_k_s[j]) << (2 * K));
		assign dgv = {1'b0, gr_s[j]} - (W1'(gt_s[j]) << (K + 1)) - (W1'(aa_k_s[j]) << (2 * K));
		always_ff @(posedge clk) begin
			if (en) begin
				rr_s[j+1]    <= dr[W] ? rr_s[j] : dr[W-1:0];
				rt_s[j+1]    <= dr[W] ? rt_s[j] : rt_s[j] + (TW'(aa_k_s[j]) << K);
				rroot_s[j+1] <= dr[W] ? rroot_s[j] : rroot_s[j] | (RW'(1) << K);
				gr_s[j+1]    <= dgv[W] ? gr_s[j] : dgv[W-1:0];
				gt_s[j+1]    <= dgv[W] ? gt_s[j] : gt_s[j] + (TW'(aa_k_s[j]) << K);
				groot_s[j+1] <= dgv[W] ? groot_s[j] : groot_s[j] | (RW'(1) << K);
				aa_k_s[j+1]  <= aa_k_s[j];
				dg_s[j+1]    <= dg_s[j];
			end
		end
	end

	// hull, squares, sum
	logic [RW-1:0] radg;
	logic [RW-1:0] h_s60, g_s60;
	pcsd_pkg::flags_t fl_s60, fl_s61;
	logic [49:0] hhh_s61, hhl_s61, hll_s61, ghh_s61, ghl_s61, gll_s61;
	logic [SW-1:0]  mrem_s [MW+1];
	logic [MW-1:0]  mroot_s [MW+1];
	pcsd_pkg::flags_t mfl_s [MW+1];

	assign radg = RW'({radius_q, 16'd0});

	always_ff @(posedge clk) begin
		if (en) begin
			fl_s60.in_rad <= rroot_s[RW] < radg;
			fl_s60.degen  <= dg_s[RW];
			h_s60 <= (rroot_s[RW] >= radg) ? rroot_s[RW] - radg : radg - rroot_s[RW];
			g_s60 <= groot_s[RW];

			hhh_s61 <= h_s60[49:25] * h_s60[49:25];
			hhl_s61 <= h_s60[49:25] * h_s60[24:0];
			hll_s61 <= h_s60[24:0] * h_s60[24:0];
			ghh_s61 <= g_s60[49:25] * g_s60[49:25];
			ghl_s61 <= g_s60[49:25] * g_s60[24:0];
			gll_s61 <= g_s60[24:0] * g_s60[24:0];
			fl_s61  <= fl_s60;

			mrem_s[0] <= ((SW'(hhh_s61) + SW'(ghh_s61)) << 50)
				+ ((SW'(hhl_s61) + SW'(ghl_s61)) << 26) + SW'(hll_s61) + SW'(gll_s61);
			mroot_s[0] <= '0;
			mfl_s[0]   <= fl_s61;
		end
	end

	for (genvar j = 0; j < MW; j++) begin : g_sqrt
		localparam int K = MW - 1 - j;
		logic [SW:0] dm;
		assign dm = {1'b0, mrem_s[j]} - (SW1'(mroot_s[j]) << (K + 1)) - (SW1'(1) << (2 * K));
		always_ff @(posedge clk) begin
			if (en) begin
				mrem_s[j+1]  <= dm[SW] ? mrem_s[j] : dm[SW-1:0];
				mroot_s[j+1] <= dm[SW] ? mroot_s[j] : mroot_s[j] | (MW'(1) << K);
				mfl_s[j+1]   <= mfl_s[j];
			end
		end
	end

	// round, saturate, sign
	logic [MW:0] rnd;
	logic [MW:0] mag;
	pcsd_pkg::coord_t dist_q;
	logic degen_q, sat_q;

	assign rnd = {1'b0, mroot_s[MW]} + ((MW + 1)'(1) << (GB - 1));
	assign mag = rnd >> GB;

	always_ff @(posedge clk) begin
		if (en) begin
			if (mfl_s[MW].degen) begin
				dist_q  <= '0;
				degen_q <= 1'b1;
				sat_q   <= 1'b0;
			end else if (mfl_s[MW].in_rad) begin
				degen_q <= 1'b0;
				if (mag > (MW + 1)'(33'h080000000)) begin
					dist_q <= 32'h80000000;
					sat_q  <= 1'b1;
				end else begin
					dist_q <= 32'(-mag);
					sat_q  <= 1'b0;
				end
			end else begin
				degen_q <= 1'b0;
				if (mag > (MW + 1)'(32'h7fffffff)) begin
					dist_q <= 32'h7fffffff;
					sat_q  <= 1'b1;
				end else begin
					dist_q <= mag[31:0];
					sat_q  <= 1'b0;
				end
			end
		end
	end

	assign result.signed_distance = dist_q;
	assign result.degenerate_axis = degen_q;
	assign result.saturated       = sat_q;

endmodule
